### src/qcss_pkg.sv
// Shared widths, register indexes and control structs of the quadratic cost segment splitter.
`default_nettype none
package qcss_pkg;

   localparam int CAP_W        = 24;
   localparam int EXON_W       = 16;
   localparam int MULT_W       = 16;
   localparam int SCALE_W      = 32;
   localparam int COST_W       = 63;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 32;

   localparam int MAX_SEGMENTS = 64;
   localparam int SEG_CNT_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   // Bound sum is one bit wider than a capacity; the dividend is sum times scale.
   localparam int SUM_W        = CAP_W + 1;
   localparam int DIVIDEND_W   = SUM_W + SCALE_W;
   localparam int DIV_BITS     = 3;
   localparam int DIV_ITERS    = (DIVIDEND_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_REG_W    = DIV_ITERS * DIV_BITS;
   localparam int ITER_W       = $clog2(DIV_ITERS);

   // The quotient is scaled in two halves to keep each multiplier small.
   localparam int QLO_W        = 32;
   localparam int QHI_W        = DIV_REG_W - QLO_W;
   localparam int PLO_W        = QLO_W + MULT_W;
   localparam int PHI_W        = QHI_W + MULT_W;
   localparam int PROD_W       = DIV_REG_W + MULT_W;

   localparam logic [CSR_INDEX_W-1:0] REG_STEP_SIZE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_COST_SCALE = CSR_INDEX_W'(1);

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef struct packed {
      logic load_item;
      logic seg;
      logic mul;
      logic div;
      logic scale;
      logic sat;
      logic emit;
   } qcss_cmd_type;

   typedef struct packed {
      logic item_empty;
      logic div_done;
      logic seg_last;
      logic out_free;
   } qcss_stat_type;

endpackage
`default_nettype wire

### src/qcss_req_if.sv
// Input channel: capacities and group count of one item.
`default_nettype none
interface qcss_req_if import qcss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CAP_W-1:0]  total_capacity;
   logic [CAP_W-1:0]  reference_capacity;
   logic [EXON_W-1:0] group_count;

   modport source (output valid, total_capacity, reference_capacity, group_count,
                   input ready);
   modport sink   (input valid, total_capacity, reference_capacity, group_count,
                   output ready);
endinterface
`default_nettype wire

### src/qcss_rsp_if.sv
// Result channel: one cost segment per transaction.
`default_nettype none
interface qcss_rsp_if import qcss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CAP_W-1:0]  segment_capacity;
   logic [COST_W-1:0] segment_cost;
   logic              last_segment;
   logic              truncated;

   modport source (output valid, segment_capacity, segment_cost, last_segment, truncated,
                   input ready);
   modport sink   (input valid, segment_capacity, segment_cost, last_segment, truncated,
                   output ready);
endinterface
`default_nettype wire

### src/qcss_csr_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface qcss_csr_if import qcss_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/qcss_ctrl.sv
// Controller state machine sequencing the segment loop of the splitter.
`default_nettype none
module qcss_ctrl import qcss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  qcss_stat_type stat,
   output qcss_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_CHECK = 8'b00000010,
      ST_SEG   = 8'b00000100,
      ST_MUL   = 8'b00001000,
      ST_DIV   = 8'b00010000,
      ST_SCALE = 8'b00100000,
      ST_SAT   = 8'b01000000,
      ST_EMIT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.item_empty ? ST_IDLE : ST_SEG;
         end
         ST_SEG: begin
            cmd.seg  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (stat.div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // The saturated cost is held here until the output register frees up.
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.seg_last ? ST_IDLE : ST_SEG;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### src/qcss_dp.sv
// Datapath: segment bounds, cost multiply, radix-8 divider, scaling and output register.
`default_nettype none
module qcss_dp import qcss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  qcss_cmd_type           cmd,
   output qcss_stat_type          stat,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [CAP_W-1:0]       in_total_capacity,
   input  logic [CAP_W-1:0]       in_reference_capacity,
   input  logic [EXON_W-1:0]      in_group_count,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [CAP_W-1:0]       out_segment_capacity,
   output logic [COST_W-1:0]      out_segment_cost,
   output logic                   out_last_segment,
   output logic                   out_truncated
);

   logic [CAP_W-1:0]     step_ff;
   logic [SCALE_W-1:0]   scale_ff;
   logic [CAP_W-1:0]     cap_ff, ref_ff, lower_ff, upper_ff;
   logic [MULT_W-1:0]    mult_ff, mult_in;
   logic [SEG_CNT_W-1:0] count_ff;
   logic                 last_ff, trunc_ff;
   logic [DIV_REG_W-1:0] div_ff, div_in;
   logic [CAP_W-1:0]     rem_ff, rem_in;
   logic [ITER_W-1:0]    iter_ff;
   logic [PLO_W-1:0]     plo_ff;
   logic [PHI_W-1:0]     phi_ff;
   logic [COST_W-1:0]    cost_ff, cost_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CAP_W-1:0]     out_cap_ff;
   logic [COST_W-1:0]    out_cost_ff;
   logic                 out_last_ff, out_trunc_ff;

   logic [CAP_W-1:0]     step_eff;
   logic [SUM_W-1:0]     up_sum, bound_sum;
   logic [CAP_W-1:0]     upper_in;
   logic                 at_max;
   logic [PROD_W-1:0]    prod_total;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= CAP_W'(1);
         scale_ff <= SCALE_W'(1);
      end else if (csr_we) begin
         if (csr_index == REG_STEP_SIZE) begin
            step_ff <= csr_data[CAP_W-1:0];
         end
         if (csr_index == REG_COST_SCALE) begin
            scale_ff <= csr_data[SCALE_W-1:0];
         end
      end
   end

   assign mult_in  = (in_group_count > EXON_W'(2)) ? MULT_W'(in_group_count - EXON_W'(2))
                                                   : MULT_W'(1);
   assign step_eff = (step_ff == '0) ? CAP_W'(1) : step_ff;
   assign up_sum   = {1'b0, lower_ff} + {1'b0, step_eff};
   assign upper_in = (up_sum > {1'b0, cap_ff}) ? cap_ff : up_sum[CAP_W-1:0];
   assign at_max   = (count_ff == SEG_CNT_W'(MAX_SEGMENTS - 1));
   assign bound_sum = {1'b0, upper_ff} + {1'b0, lower_ff};

   // Three restoring division steps per cycle; quotient bits shift in at the bottom.
   always_comb begin
      logic [CAP_W:0] trial;
      logic [CAP_W-1:0] rem_v;
      logic [DIV_REG_W-1:0] div_v;
      rem_v = rem_ff;
      div_v = div_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {rem_v, div_v[DIV_REG_W-1]};
         div_v = {div_v[DIV_REG_W-2:0], 1'b0};
         if (trial >= {1'b0, ref_ff}) begin
            trial    = trial - {1'b0, ref_ff};
            div_v[0] = 1'b1;
         end
         rem_v = trial[CAP_W-1:0];
      end
      rem_in = rem_v;
      div_in = div_v;
   end

   assign prod_total = {phi_ff, {QLO_W{1'b0}}} + {{(PROD_W-PLO_W){1'b0}}, plo_ff};
   assign cost_in    = (prod_total[PROD_W-1:COST_W] != '0) ? COST_MAX
                                                           : prod_total[COST_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cap_ff   <= in_total_capacity;
         ref_ff   <= in_reference_capacity;
         mult_ff  <= mult_in;
         lower_ff <= '0;
         count_ff <= '0;
      end
      if (cmd.seg) begin
         upper_ff <= upper_in;
         last_ff  <= (upper_in == cap_ff) || at_max;
         trunc_ff <= (upper_in != cap_ff) && at_max;
      end
      if (cmd.mul) begin
         div_ff  <= DIV_REG_W'(bound_sum) * DIV_REG_W'(scale_ff);
         rem_ff  <= '0;
         iter_ff <= '0;
      end
      if (cmd.div) begin
         div_ff  <= div_in;
         rem_ff  <= rem_in;
         iter_ff <= iter_ff + ITER_W'(1);
      end
      if (cmd.scale) begin
         plo_ff <= PLO_W'(div_ff[QLO_W-1:0]) * PLO_W'(mult_ff);
         phi_ff <= PHI_W'(div_ff[DIV_REG_W-1:QLO_W]) * PHI_W'(mult_ff);
      end
      if (cmd.sat) begin
         cost_ff <= cost_in;
      end
      if (cmd.emit) begin
         out_cap_ff   <= upper_ff - lower_ff;
         out_cost_ff  <= cost_ff;
         out_last_ff  <= last_ff;
         out_trunc_ff <= trunc_ff;
         lower_ff     <= upper_ff;
         count_ff     <= count_ff + SEG_CNT_W'(1);
      end
   end

   // The output register is taken by the sink independently of the segment loop.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign stat.item_empty = (cap_ff == '0) || (ref_ff == '0);
   assign stat.div_done   = (iter_ff == ITER_W'(DIV_ITERS - 1));
   assign stat.seg_last   = last_ff;
   assign stat.out_free   = !out_valid_ff || out_ready;

   assign out_valid            = out_valid_ff;
   assign out_segment_capacity = out_cap_ff;
   assign out_segment_cost     = out_cost_ff;
   assign out_last_segment     = out_last_ff;
   assign out_truncated        = out_trunc_ff;

endmodule
`default_nettype wire

### src/quadratic_cost_segment_splitter.sv
// Top level of the quadratic cost segment splitter.
// Each input transaction splits total_capacity into step_size wide segments plus a
// leftover and returns one result transaction per segment, at most 64, with the
// per-unit cost floor((upper + lower) * cost_scale / reference_capacity) times
// max(1, group_count - 2), saturated at 2^63-1. An item with zero capacity or zero
// reference returns nothing and goes from the check state back to idle. Otherwise
// each segment passes through the bound, multiply, divide, scale, saturate and emit
// states; the divide state runs the shared divider, which retires three quotient bits
// per cycle. A segment waits in its emit state while the previous result has not been
// taken. A new input is accepted only after the last segment of the previous one has
// entered the output register, which may still be waiting for its sink.
`default_nettype none
module quadratic_cost_segment_splitter import qcss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   qcss_req_if.sink     req,
   qcss_rsp_if.source   rsp,
   qcss_csr_if.sink     csr
);

   qcss_cmd_type  cmd;
   qcss_stat_type stat;
   logic          csr_we;

   assign csr.ready = 1'b1;
   assign csr_we    = csr.valid;

   qcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   qcss_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_we                (csr_we),
      .csr_index             (csr.index),
      .csr_data              (csr.data),
      .in_total_capacity     (req.total_capacity),
      .in_reference_capacity (req.reference_capacity),
      .in_group_count        (req.group_count),
      .out_valid             (rsp.valid),
      .out_ready             (rsp.ready),
      .out_segment_capacity  (rsp.segment_capacity),
      .out_segment_cost      (rsp.segment_cost),
      .out_last_segment      (rsp.last_segment),
      .out_truncated         (rsp.truncated)
   );

endmodule
`default_nettype wire
